// ----- hw/rtl/text_to_unsigned64_converter_top_defines.svh -----
// Assertion macros for the text-to-unsigned converter.
// Each checks on the rising edge of clk and is quiet while rst is high.
`ifndef TEXT_TO_UNSIGNED64_CONVERTER_TOP_DEFINES_SVH
`define TEXT_TO_UNSIGNED64_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define T2U64_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define T2U64_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/t2u64_pkg.sv -----
package t2u64_pkg;

  // Input word: one character of the stream.
  typedef struct packed {
    logic        start_of_string;
    logic [15:0] char_code;
  } in_word_t;

  // Result word: one finished conversion.
  typedef struct packed {
    logic [63:0] value;
    logic        overflow;
    logic [15:0] stop_position;
  } out_word_t;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  // Letter offsets: 'a' - 10 and 'A' - 10.
  localparam logic [7:0] LO_LETTER_BIAS = 8'h57;
  localparam logic [7:0] UP_LETTER_BIAS = 8'h37;

  // Bases.
  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_BIN  = 6'd2;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;

endpackage

// ----- hw/rtl/text_to_unsigned64_converter_top.sv -----
// Channel    Dir  Handshake              Payload
// --------   ---  ---------------------  ---------------------------------------
// in         in   in_valid / in_ready    in_data  : start_of_string, char_code
// out        out  out_valid / out_ready  out_data : value, overflow, stop_position
// cfg        in   cfg_write_en           cfg_write_data : number_base (6 bits)
//
// Each character passes the input register, then the parse step into the
// result register; one character is taken every cycle unless a result stalls.
// The per-character step is one 64x6 multiply-add plus the prefix decode.
// Reset (rst, synchronous) clears the parser to leading whitespace, base 0.
// A stalled result stops the parse step; in_ready drops only when the input
// register is full and the result register is held by out_ready low.
`include "text_to_unsigned64_converter_top_defines.svh"

module text_to_unsigned64_converter_top #(
  parameter int POSITION_BITS = 16,
  parameter int CHAR_BITS     = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  t2u64_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output t2u64_pkg::out_word_t out_data,
  input  logic                 cfg_write_en,
  input  logic [5:0]           cfg_write_data
);

  // Only the low CW bits of a character are significant.
  localparam int CW = (CHAR_BITS < 16) ? CHAR_BITS : 16;

  // Parser phases.
  localparam logic [2:0] PH_SPACE      = 3'd0;
  localparam logic [2:0] PH_PREFIX     = 3'd1;
  localparam logic [2:0] PH_AUTO_ZERO  = 3'd2;
  localparam logic [2:0] PH_FIXED_ZERO = 3'd3;
  localparam logic [2:0] PH_DIGITS     = 3'd4;
  localparam logic [2:0] PH_DONE       = 3'd5;

  // Configuration register.
  logic [5:0] number_base;

  // Input register.
  t2u64_pkg::in_word_t in_q;
  logic                in_q_valid;

  // Conversion state.
  logic [2:0]               phase;
  logic [5:0]               active_base;
  logic [63:0]              accumulator;
  logic                     overflow_seen;
  logic [POSITION_BITS-1:0] consumed_count;

  logic [2:0]               phase_next;
  logic [5:0]               active_base_next;
  logic [63:0]              accumulator_next;
  logic                     overflow_seen_next;
  logic [POSITION_BITS-1:0] consumed_count_next;

  // Current state with a start-of-string clear applied.
  logic [2:0]               ph_cur;
  logic [5:0]               base_cur;
  logic [63:0]              acc_cur;
  logic                     ovf_cur;
  logic [POSITION_BITS-1:0] cnt_cur;

  // Character decode.
  logic [CW-1:0] ch;
  logic          is_ws, is_plus, is_zero, is_x, is_b;
  logic          is_num, is_lower, is_upper, dig_ok;
  logic [5:0]    dig;

  logic       take, do_prefix, go_digits, emit, fire;
  logic [5:0] dig_base;
  logic [69:0] mac;

  // A parse step runs whenever a character is held and the result slot is free.
  assign fire     = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= t2u64_pkg::BASE_AUTO;
    end else if (cfg_write_en) begin
      number_base <= cfg_write_data;
    end
  end

  // Load the input register; drop its valid once the step consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  assign ph_cur   = in_q.start_of_string ? PH_SPACE : phase;
  assign base_cur = in_q.start_of_string ? 6'd0 : active_base;
  assign acc_cur  = in_q.start_of_string ? 64'd0 : accumulator;
  assign ovf_cur  = in_q.start_of_string ? 1'b0 : overflow_seen;
  assign cnt_cur  = in_q.start_of_string ? '0 : consumed_count;

  assign ch = in_q.char_code[CW-1:0];

  assign is_ws    = (ch == CW'(t2u64_pkg::CH_SPACE)) ||
                    ((ch >= CW'(t2u64_pkg::CH_TAB)) && (ch <= CW'(t2u64_pkg::CH_CR)));
  assign is_plus  = (ch == CW'(t2u64_pkg::CH_PLUS));
  assign is_zero  = (ch == CW'(t2u64_pkg::CH_ZERO));
  assign is_x     = (ch == CW'(t2u64_pkg::CH_LO_X)) || (ch == CW'(t2u64_pkg::CH_UP_X));
  assign is_b     = (ch == CW'(t2u64_pkg::CH_LO_B)) || (ch == CW'(t2u64_pkg::CH_UP_B));
  assign is_num   = (ch >= CW'(t2u64_pkg::CH_ZERO)) && (ch <= CW'(t2u64_pkg::CH_NINE));
  assign is_lower = (ch >= CW'(t2u64_pkg::CH_LO_A)) && (ch <= CW'(t2u64_pkg::CH_LO_Z));
  assign is_upper = (ch >= CW'(t2u64_pkg::CH_UP_A)) && (ch <= CW'(t2u64_pkg::CH_UP_Z));
  assign dig_ok   = is_num || is_lower || is_upper;

  always_comb begin
    priority if (is_num) begin
      dig = 6'(ch[7:0] - t2u64_pkg::CH_ZERO);
    end else if (is_lower) begin
      dig = 6'(ch[7:0] - t2u64_pkg::LO_LETTER_BIAS);
    end else if (is_upper) begin
      dig = 6'(ch[7:0] - t2u64_pkg::UP_LETTER_BIAS);
    end else begin
      dig = 6'd0;
    end
  end

  // Multiply-add by the base; anything above bit 63 is an overflow.
  assign mac = 70'(acc_cur) * 70'(dig_base) + 70'(dig);

  // Parse step. Phases fall through (whitespace -> prefix -> digits) within
  // one character, the same way the sequential scan would.
  always_comb begin
    phase_next         = ph_cur;
    active_base_next   = base_cur;
    accumulator_next   = acc_cur;
    overflow_seen_next = ovf_cur;
    take               = 1'b0;
    do_prefix          = 1'b0;
    go_digits          = 1'b0;
    dig_base           = base_cur;
    emit               = 1'b0;

    unique case (ph_cur)
      PH_SPACE: begin
        if (is_ws) begin
          take = 1'b1;
        end else if (is_plus) begin
          take       = 1'b1;
          phase_next = PH_PREFIX;
        end else begin
          do_prefix = 1'b1;
        end
      end
      PH_PREFIX: begin
        do_prefix = 1'b1;
      end
      PH_AUTO_ZERO: begin
        phase_next = PH_DIGITS;
        if (is_x) begin
          active_base_next = t2u64_pkg::BASE_HEX;
          take             = 1'b1;
        end else if (is_b) begin
          active_base_next = t2u64_pkg::BASE_BIN;
          take             = 1'b1;
        end else begin
          go_digits = 1'b1;
        end
      end
      PH_FIXED_ZERO: begin
        phase_next = PH_DIGITS;
        if (((base_cur == t2u64_pkg::BASE_HEX) && is_x) ||
            ((base_cur == t2u64_pkg::BASE_BIN) && is_b)) begin
          take = 1'b1;
        end else begin
          go_digits = 1'b1;
        end
      end
      PH_DIGITS: begin
        go_digits = 1'b1;
      end
      default: ;
    endcase

    // Latch the base; with automatic detection a leading zero picks octal.
    if (do_prefix) begin
      if (number_base == t2u64_pkg::BASE_AUTO) begin
        if (is_zero) begin
          take             = 1'b1;
          active_base_next = t2u64_pkg::BASE_OCT;
          phase_next       = PH_AUTO_ZERO;
        end else begin
          active_base_next = t2u64_pkg::BASE_DEC;
          phase_next       = PH_DIGITS;
          go_digits        = 1'b1;
          dig_base         = t2u64_pkg::BASE_DEC;
        end
      end else begin
        active_base_next = number_base;
        if (((number_base == t2u64_pkg::BASE_HEX) || (number_base == t2u64_pkg::BASE_BIN)) &&
            is_zero) begin
          take       = 1'b1;
          phase_next = PH_FIXED_ZERO;
        end else begin
          phase_next = PH_DIGITS;
          go_digits  = 1'b1;
          dig_base   = number_base;
        end
      end
    end

    // Accumulate a digit below the base, else close out the string.
    if (go_digits) begin
      if (dig_ok && (dig < dig_base)) begin
        accumulator_next = mac[63:0];
        if (mac[69:64] != 6'd0) begin
          overflow_seen_next = 1'b1;
        end
        take       = 1'b1;
        phase_next = PH_DIGITS;
      end else begin
        emit       = 1'b1;
        phase_next = PH_DONE;
      end
    end

    // Saturating count of consumed characters.
    if (take && (cnt_cur != {POSITION_BITS{1'b1}})) begin
      consumed_count_next = cnt_cur + 1'b1;
    end else begin
      consumed_count_next = cnt_cur;
    end
  end

  // Advance the conversion state once per parsed character.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SPACE;
      active_base    <= 6'd0;
      accumulator    <= 64'd0;
      overflow_seen  <= 1'b0;
      consumed_count <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      active_base    <= active_base_next;
      accumulator    <= accumulator_next;
      overflow_seen  <= overflow_seen_next;
      consumed_count <= consumed_count_next;
    end
  end

  // Result register: load on emit, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_data.value         <= ovf_cur ? {64{1'b1}} : acc_cur;
      out_data.overflow      <= ovf_cur;
      out_data.stop_position <= 16'(cnt_cur);
    end
  end

  `T2U64_ASSERT_NOW(a_ovf_all_ones, out_valid && out_data.overflow, &out_data.value, "overflow result is not all ones")
  `T2U64_ASSERT_NEXT(a_emit_done, fire && emit, phase == PH_DONE, "parser not done after result")
  `T2U64_ASSERT_NOW(a_stall_cause, !in_ready, in_q_valid && out_valid && !out_ready, "input stalled without a held result")
  `T2U64_ASSERT_NEXT(a_count_mono, fire && !in_q.start_of_string, consumed_count >= $past(consumed_count), "consumed count went backward")

endmodule

// ----- sim/tb_text_to_unsigned64_converter_top.sv -----
module tb_text_to_unsigned64_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Characters the stimulus needs beyond the ones the package names.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Bases beyond the named ones: the smallest, the largest legal one, and
  // the widest the register can hold.
  localparam logic [5:0] BASE_UNIT = 6'd1;
  localparam logic [5:0] BASE_MAX  = 6'd36;
  localparam logic [5:0] BASE_WIDE = 6'd63;

  localparam int RANDOM_ITEMS  = 330;
  localparam int SETTLE_CYCLES = 6;          // two-stage pipe plus margin
  localparam int CYCLE_LIMIT   = 1_000_000;

  // Parser phases, tracked by the prediction below.
  typedef enum logic [2:0] {
    SCAN_SPACE,
    SCAN_PREFIX,
    SCAN_AUTO_ZERO,
    SCAN_FIXED_ZERO,
    SCAN_DIGITS,
    SCAN_DONE
  } scan_phase_e;

  // Receiver behavior, switched after each random stretch.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_SHUT
  } rx_mode_e;

  logic                  clk            = 1'b0;
  logic                  rst            = 1'b1;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  t2u64_pkg::in_word_t   in_data        = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  t2u64_pkg::out_word_t  out_data;
  logic                  cfg_write_en   = 1'b0;
  logic [5:0]            cfg_write_data = '0;

  // Predicted parser state; starts at its reset value.
  logic [5:0]  radix_setting  = t2u64_pkg::BASE_AUTO;
  scan_phase_e scan           = SCAN_SPACE;
  logic [5:0]  scan_base      = '0;
  logic [63:0] acc            = '0;
  logic        acc_overflow   = 1'b0;
  logic [15:0] consumed       = '0;

  t2u64_pkg::out_word_t pending_conversions [$];
  bit          mismatch_seen  = 1'b0;
  int          cycle_count    = 0;

  // Sender pacing and string bookkeeping.
  bit          gaps_enabled   = 1'b1;
  int          burst_left     = 0;
  bit          fresh_string   = 1'b0;
  int          chars_sent     = 0;

  rx_mode_e    rx_mode        = RX_OPEN;
  int          rx_left        = 0;

  text_to_unsigned64_converter_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Count one consumed character, holding at the top of the 16-bit range.
  function automatic void take_char();
    if (consumed != 16'hFFFF) consumed = consumed + 16'd1;
  endfunction

  // Advance the predicted parser by one accepted word; queue a conversion
  // when the word ends the number.
  function automatic void convert_char(input t2u64_pkg::in_word_t w);
    logic [15:0]          ch;
    logic [7:0]           lo;
    bit                   narrow;
    int                   dig;
    logic [69:0]          wide;
    bit                   settled;
    t2u64_pkg::out_word_t res;
    ch = w.char_code;
    // A code only matches an ASCII character when its high byte is zero.
    narrow = (ch[15:8] == 8'h00);
    lo     = ch[7:0];
    if (w.start_of_string) begin
      scan         = SCAN_SPACE;
      scan_base    = '0;
      acc          = '0;
      acc_overflow = 1'b0;
      consumed     = '0;
    end
    settled = 1'b0;
    // A character that leaves a phase without being consumed is looked at
    // again by the next phase, so loop until one phase settles it.
    while (!settled) begin
      settled = 1'b1;
      case (scan)
        SCAN_SPACE: begin
          if (narrow && (lo == t2u64_pkg::CH_SPACE ||
                         (lo >= t2u64_pkg::CH_TAB && lo <= t2u64_pkg::CH_CR))) begin
            take_char();
          end else begin
            scan = SCAN_PREFIX;
            if (narrow && lo == t2u64_pkg::CH_PLUS) take_char();
            else settled = 1'b0;
          end
        end
        SCAN_PREFIX: begin
          if (radix_setting == t2u64_pkg::BASE_AUTO) begin
            if (narrow && lo == t2u64_pkg::CH_ZERO) begin
              take_char();
              scan_base = t2u64_pkg::BASE_OCT;
              scan      = SCAN_AUTO_ZERO;
            end else begin
              scan_base = t2u64_pkg::BASE_DEC;
              scan      = SCAN_DIGITS;
              settled   = 1'b0;
            end
          end else begin
            scan_base = radix_setting;
            if ((radix_setting == t2u64_pkg::BASE_HEX ||
                 radix_setting == t2u64_pkg::BASE_BIN) &&
                narrow && lo == t2u64_pkg::CH_ZERO) begin
              take_char();
              scan = SCAN_FIXED_ZERO;
            end else begin
              scan    = SCAN_DIGITS;
              settled = 1'b0;
            end
          end
        end
        SCAN_AUTO_ZERO: begin
          scan = SCAN_DIGITS;
          if (narrow && (lo == t2u64_pkg::CH_LO_X || lo == t2u64_pkg::CH_UP_X)) begin
            scan_base = t2u64_pkg::BASE_HEX;
            take_char();
          end else if (narrow && (lo == t2u64_pkg::CH_LO_B || lo == t2u64_pkg::CH_UP_B)) begin
            scan_base = t2u64_pkg::BASE_BIN;
            take_char();
          end else begin
            settled = 1'b0;
          end
        end
        SCAN_FIXED_ZERO: begin
          scan = SCAN_DIGITS;
          if (narrow &&
              ((scan_base == t2u64_pkg::BASE_HEX &&
                (lo == t2u64_pkg::CH_LO_X || lo == t2u64_pkg::CH_UP_X)) ||
               (scan_base == t2u64_pkg::BASE_BIN &&
                (lo == t2u64_pkg::CH_LO_B || lo == t2u64_pkg::CH_UP_B)))) begin
            take_char();
          end else begin
            settled = 1'b0;
          end
        end
        SCAN_DIGITS: begin
          dig = 255;
          if (narrow && lo >= t2u64_pkg::CH_ZERO && lo <= t2u64_pkg::CH_NINE)
            dig = int'(lo - t2u64_pkg::CH_ZERO);
          else if (narrow && lo >= t2u64_pkg::CH_LO_A && lo <= t2u64_pkg::CH_LO_Z)
            dig = int'(lo - t2u64_pkg::LO_LETTER_BIAS);
          else if (narrow && lo >= t2u64_pkg::CH_UP_A && lo <= t2u64_pkg::CH_UP_Z)
            dig = int'(lo - t2u64_pkg::UP_LETTER_BIAS);
          if (dig < int'(scan_base)) begin
            // Keep the full product so a carry out of 64 bits is visible.
            wide = 70'(acc) * 70'(scan_base) + 70'(dig);
            if (wide[69:64] != '0) acc_overflow = 1'b1;
            acc = wide[63:0];
            take_char();
          end else begin
            res.value         = acc_overflow ? {64{1'b1}} : acc;
            res.overflow      = acc_overflow;
            res.stop_position = consumed;
            pending_conversions.push_back(res);
            scan = SCAN_DONE;
          end
        end
        default: ;  // silent until the next start of string
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: track config writes, predict accepted words, check results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    t2u64_pkg::out_word_t want;
    if (!rst) begin
      if (cfg_write_en) radix_setting = cfg_write_data;
      if (in_valid && in_ready) convert_char(in_data);
      if (out_valid && out_ready) begin
        if (pending_conversions.size() == 0) begin
          $error("unexpected result word: value %h overflow %b stop_position %0d",
                 out_data.value, out_data.overflow, out_data.stop_position);
          mismatch_seen = 1'b1;
        end else begin
          want = pending_conversions.pop_front();
          if (out_data.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, out_data.value);
            mismatch_seen = 1'b1;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, out_data.overflow);
            mismatch_seen = 1'b1;
          end
          if (out_data.stop_position !== want.stop_position) begin
            $error("stop_position: expected %0d, got %0d",
                   want.stop_position, out_data.stop_position);
            mismatch_seen = 1'b1;
          end
        end
      end
    end
  end

  // Receiver: hold each mode for a random stretch, from wide open to shut.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(4, 48);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default:   out_ready <= 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Drive one word and hold it until it is taken. Between bursts drop
  // valid for a random pause.
  task automatic send_char(input logic sos, input logic [15:0] code);
    if (gaps_enabled && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{start_of_string: sos, char_code: code};
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  // Send the next character of the current string; the first one carries
  // the start-of-string flag.
  task automatic put_char(input logic [15:0] code);
    send_char(fresh_string, code);
    fresh_string = 1'b0;
  endtask

  task automatic send_text(input string s, input bit fresh);
    int i;
    if (fresh) fresh_string = 1'b1;
    for (i = 0; i < s.len(); i++) put_char(16'(s[i]));
  endtask

  // Character for digit d, letters in a random case.
  function automatic logic [15:0] digit_char(input int d);
    if (d < 10) return 16'(t2u64_pkg::CH_ZERO) + 16'(d);
    if ($urandom_range(0, 1)) return 16'(t2u64_pkg::LO_LETTER_BIAS) + 16'(d);
    return 16'(t2u64_pkg::UP_LETTER_BIAS) + 16'(d);
  endfunction

  // Drop valid and wait until every predicted conversion has come out, then
  // let the pipe settle in case a word that ends nothing is still inside.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_conversions.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_number_base(input logic [5:0] base);
    drain_results();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= base;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // One random string under the given base setting: mostly well formed,
  // some left unterminated, some pure noise.
  task automatic send_random_string(input logic [5:0] cfg);
    int pick;
    int radix;
    int ndig;
    int k;
    pick = $urandom_range(0, 99);
    fresh_string = 1'b1;
    if (pick >= 85) begin
      repeat ($urandom_range(1, 8))
        put_char($urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(0, 127)));
      return;
    end
    // Leading whitespace: tab through carriage return, or space.
    repeat ($urandom_range(0, 2)) begin
      k = $urandom_range(0, 5);
      put_char((k == 5) ? 16'(t2u64_pkg::CH_SPACE) : 16'(t2u64_pkg::CH_TAB) + 16'(k));
    end
    if ($urandom_range(0, 2) == 0) put_char(16'(t2u64_pkg::CH_PLUS));
    if (cfg == t2u64_pkg::BASE_AUTO) begin
      case ($urandom_range(0, 3))
        0: radix = int'(t2u64_pkg::BASE_DEC);
        1: begin
          radix = int'(t2u64_pkg::BASE_OCT);
          put_char(16'(t2u64_pkg::CH_ZERO));
        end
        2: begin
          radix = int'(t2u64_pkg::BASE_HEX);
          put_char(16'(t2u64_pkg::CH_ZERO));
          put_char(16'($urandom_range(0, 1) ? t2u64_pkg::CH_LO_X : t2u64_pkg::CH_UP_X));
        end
        default: begin
          radix = int'(t2u64_pkg::BASE_BIN);
          put_char(16'(t2u64_pkg::CH_ZERO));
          put_char(16'($urandom_range(0, 1) ? t2u64_pkg::CH_LO_B : t2u64_pkg::CH_UP_B));
        end
      endcase
    end else begin
      radix = (cfg > BASE_MAX) ? int'(BASE_MAX) : int'(cfg);
      if (cfg == t2u64_pkg::BASE_HEX && $urandom_range(0, 1)) begin
        put_char(16'(t2u64_pkg::CH_ZERO));
        put_char(16'($urandom_range(0, 1) ? t2u64_pkg::CH_LO_X : t2u64_pkg::CH_UP_X));
      end else if (cfg == t2u64_pkg::BASE_BIN && $urandom_range(0, 1)) begin
        put_char(16'(t2u64_pkg::CH_ZERO));
        put_char(16'($urandom_range(0, 1) ? t2u64_pkg::CH_LO_B : t2u64_pkg::CH_UP_B));
      end
    end
    // Mostly short numbers; now and then a run long enough to overflow.
    ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 70) : $urandom_range(0, 10);
    for (k = 0; k < ndig; k++) begin
      if (cfg == t2u64_pkg::BASE_AUTO && radix == int'(t2u64_pkg::BASE_DEC) && k == 0)
        put_char(digit_char($urandom_range(1, 9)));
      else
        put_char(digit_char($urandom_range(0, radix - 1)));
    end
    if (pick >= 75) return;  // leave it open; the next string restarts it
    case ($urandom_range(0, 5))
      0: put_char(16'(CH_MINUS));
      1: put_char(16'(t2u64_pkg::CH_SPACE));
      2: put_char(16'(CH_DOT));
      3: put_char(16'($urandom_range(256, 65535)));
      4: put_char((radix < int'(BASE_MAX)) ? digit_char($urandom_range(radix, 35))
                                            : 16'(CH_DOT));
      default: put_char(16'(CH_NUL));
    endcase
    // Trailing junk after the number must stay silent.
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) put_char(16'($urandom_range(0, 65535)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Automatic base detection, straight out of reset.
  task automatic test_auto_prefixes();
    fresh_string = 1'b1;
    put_char(16'(t2u64_pkg::CH_TAB));
    put_char(16'(t2u64_pkg::CH_SPACE));
    send_text("+0xFf-", 1'b0);     // hex, mixed case, minus ends it
    send_text("078", 1'b1);        // octal, 8 is not a digit
    send_text("0B12", 1'b1);       // binary prefix
    send_text("0X!", 1'b1);        // prefix with no digits
    send_text("-5", 1'b1);         // minus is not a sign here
    send_text("9", 1'b1);
    put_char({8'hFF, t2u64_pkg::CH_NINE});  // wide code whose low byte is a digit
    send_text("12", 1'b1);         // unterminated, then restarted
    send_text("3.", 1'b1);
    send_text("x", 1'b0);          // after the result: no word out
  endtask

  task automatic test_fixed_bases();
    set_number_base(t2u64_pkg::BASE_HEX);
    send_text("0x1Ag", 1'b1);
    send_text("01 ", 1'b1);        // zero not followed by x
    set_number_base(t2u64_pkg::BASE_BIN);
    send_text("0b1012", 1'b1);
    set_number_base(BASE_UNIT);
    send_text("001", 1'b1);        // only zero counts as a digit
    set_number_base(BASE_MAX);
    send_text("zZ{", 1'b1);
    set_number_base(BASE_WIDE);
    send_text("+z0!", 1'b1);       // every letter is a digit
    set_number_base(t2u64_pkg::BASE_DEC);
    send_text("0x", 1'b1);         // no prefix skipping in base 10
  endtask

  // Values right at and just past the 64-bit edge in several bases.
  task automatic test_overflow_edges();
    set_number_base(t2u64_pkg::BASE_DEC);
    send_text("18446744073709551615 ", 1'b1);
    send_text("18446744073709551616 ", 1'b1);
    set_number_base(t2u64_pkg::BASE_HEX);
    fresh_string = 1'b1;
    repeat (16) put_char(digit_char(15));
    put_char(16'(CH_DOT));
    fresh_string = 1'b1;
    repeat (17) put_char(digit_char(15));
    put_char(16'(CH_DOT));
    set_number_base(t2u64_pkg::BASE_BIN);
    fresh_string = 1'b1;
    repeat (65) put_char(16'(t2u64_pkg::CH_ZERO + 8'd1));
    put_char(16'(t2u64_pkg::CH_ZERO + 8'd2));
    set_number_base(t2u64_pkg::BASE_AUTO);
    send_text("0x1", 1'b1);
    repeat (16) put_char(16'(t2u64_pkg::CH_ZERO));
    put_char(16'(t2u64_pkg::CH_LO_A + 8'd6));
  endtask

  // Random strings over a series of base settings, pausing now and then
  // until everything has come out.
  task automatic test_random_streams();
    logic [5:0] plan [7] = '{t2u64_pkg::BASE_AUTO, BASE_MAX, t2u64_pkg::BASE_BIN,
                             t2u64_pkg::BASE_HEX, t2u64_pkg::BASE_DEC,
                             t2u64_pkg::BASE_OCT, BASE_UNIT};
    logic [5:0] base;
    int         step;
    int         start;
    int         phase_end;
    step  = 0;
    start = chars_sent;
    while (chars_sent - start < RANDOM_ITEMS) begin
      base = (step < 7) ? plan[3'(step)] : 6'($urandom_range(0, 36));
      step++;
      set_number_base(base);
      phase_end = chars_sent + $urandom_range(40, 80);
      while (chars_sent < phase_end && chars_sent - start < RANDOM_ITEMS) begin
        send_random_string(base);
        if ($urandom_range(0, 29) == 0) drain_results();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_auto_prefixes();
    test_fixed_bases();
    test_overflow_edges();
    test_random_streams();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!mismatch_seen) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop if the run hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results still expected",
           cycle_count, pending_conversions.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/t2u64_pkg.sv
hw/rtl/text_to_unsigned64_converter_top.sv
sim/tb_text_to_unsigned64_converter_top.sv
